@@ src/key_event_match_filter_macros.svh @@
// Assertion macros shared by the checker of the key event match filter.
`ifndef KEY_EVENT_MATCH_FILTER_MACROS_SVH
`define KEY_EVENT_MATCH_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KEF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/kef_pkg.sv @@
// Package with the types, codes and sizes of the key event match filter.
`default_nettype none

package kef_pkg;

	localparam int DEF_CODE_SLOTS     = 16;
	localparam int DEF_POSITION_SLOTS = 16;

	localparam int ENTRY_W    = 16;
	localparam int FUNC_W     = 3;
	localparam int HELD_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	localparam logic [HELD_W-1:0] HELD_MAX = '1;

	localparam logic [FUNC_W-1:0] FN_KEY      = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ADD_CODE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_REM_CODE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_ADD_POS  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REM_POS  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_ENABLE   = 3'd5;
	localparam logic [FUNC_W-1:0] FN_DISABLE  = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_TOGGLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISABLE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} kef_state_t;

	// Command driven into one row of cells.
	typedef struct packed {
		logic cmp;     // register the per-cell hit bits
		logic add;     // append the value at the first empty cell
		logic remove;  // close the gap from the first hit upward
	} kef_cmd_t;

endpackage

`default_nettype wire

@@ src/kef_cell.sv @@
// One list cell: an entry, its valid bit and its registered hit flag.
`default_nettype none

module kef_cell
	import kef_pkg::*;
(
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  kef_cmd_t           cmd,
	input  wire  logic [ENTRY_W-1:0] value,
	input  wire  logic               prev_valid,
	input  wire  logic               shift,
	input  wire  logic [ENTRY_W-1:0] next_entry,
	input  wire  logic               next_valid,
	output logic [ENTRY_W-1:0]       entry,
	output logic                     valid,
	output logic                     hit
);

	logic [ENTRY_W-1:0] entry_q;
	logic               valid_q;
	logic               hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.cmp) begin
				hit_q <= valid_q && (entry_q == value);
			end
			if (cmd.add && !valid_q && prev_valid) begin
				valid_q <= 1'b1;
			end else if (cmd.remove && shift) begin
				valid_q <= next_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add && !valid_q && prev_valid) begin
			entry_q <= value;
		end else if (cmd.remove && shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign hit   = hit_q;

endmodule

`default_nettype wire

@@ src/kef_list.sv @@
// Compacting match list built as a row of cells that shift toward slot zero.
`default_nettype none

module kef_list
	import kef_pkg::*;
#(
	parameter int SLOTS = DEF_CODE_SLOTS
) (
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  kef_cmd_t           cmd,
	input  wire  logic [ENTRY_W-1:0] value,
	output logic                     found
);

	logic [ENTRY_W-1:0] entry_vec [SLOTS];
	logic [SLOTS-1:0]   valid_vec;
	logic [SLOTS-1:0]   hit_vec;
	logic [SLOTS-1:0]   shift_vec;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic               prev_valid;
		logic [ENTRY_W-1:0] next_entry;
		logic               next_valid;

		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_mid
			assign prev_valid = valid_vec[i-1];
		end

		if (i == SLOTS - 1) begin : g_last
			assign next_entry = '0;
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_entry = entry_vec[i+1];
			assign next_valid = valid_vec[i+1];
		end

		// A cell moves its upper neighbor down once the removed entry lies at or below it.
		assign shift_vec[i] = |hit_vec[i:0];

		kef_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.value      (value),
			.prev_valid (prev_valid),
			.shift      (shift_vec[i]),
			.next_entry (next_entry),
			.next_valid (next_valid),
			.entry      (entry_vec[i]),
			.valid      (valid_vec[i]),
			.hit        (hit_vec[i])
		);
	end

	assign found = |hit_vec;

endmodule

`default_nettype wire

@@ src/key_event_match_filter.sv @@
// Top level of the key event match filter: item capture, control flag, held count.
// An accepted word gets one compare pass and one update pass over the two rows of list
// cells, and its result is registered on m_tdata in the update pass, which waits while
// an earlier result is not yet taken. No new word is taken until that update is done.
// Reset (arst_n low, asynchronous): lists empty, held count zero, filter disabled,
// all three control codes zero, no result pending.
`default_nettype none

module key_event_match_filter
	import kef_pkg::*;
#(
	parameter int CODE_SLOTS     = DEF_CODE_SLOTS,
	parameter int POSITION_SLOTS = DEF_POSITION_SLOTS
) (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	input  wire  logic                  s_tvalid,
	output logic                        s_tready,
	input  wire  logic [IN_DATA_W-1:0]  s_tdata,  // keycode, row, col, pressed, zero pad
	input  wire  logic [FUNC_W-1:0]     s_tuser,  // func
	output logic                        m_tvalid,
	input  wire  logic                  m_tready,
	// pass_through, tone_start, tone_stop, matched, is_active, zero pad
	output logic [OUT_DATA_W-1:0]       m_tdata,
	input  wire  logic                  cfg_we,
	input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire  logic [CFG_DATA_W-1:0] cfg_data
);

	// Control code registers; the user must write them only while the block is idle (not enforced here).
	logic [CFG_DATA_W-1:0] toggle_code_q;
	logic [CFG_DATA_W-1:0] enable_code_q;
	logic [CFG_DATA_W-1:0] disable_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_code_q  <= '0;
			enable_code_q  <= '0;
			disable_code_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOGGLE:  toggle_code_q  <= cfg_data;
				REG_ENABLE:  enable_code_q  <= cfg_data;
				REG_DISABLE: disable_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The accepted word is held for the whole compare and update sequence.
	logic [FUNC_W-1:0]  func_q;
	logic [ENTRY_W-1:0] keycode_q;
	logic [7:0]         row_q;
	logic [7:0]         col_q;
	logic               pressed_q;

	logic s_fire;
	assign s_fire = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (s_fire) begin
			keycode_q <= s_tdata[15:0];
			row_q     <= s_tdata[23:16];
			col_q     <= s_tdata[31:24];
			pressed_q <= s_tdata[32];
			func_q    <= s_tuser;
		end
	end

	// Sequencer. The update step waits until the output register can take the result,
	// so every state change happens exactly once per word.
	kef_state_t state_q;
	kef_state_t state_d;
	logic       out_free;
	logic       apply;

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		apply    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (out_free) begin
					apply   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The two cell rows. Each row registers its hit bits in the compare step; in the
	// update step the found flags steer adds (only when absent) and removes (only when
	// present). An add into a full row finds no empty cell and does nothing.
	kef_cmd_t           code_cmd;
	kef_cmd_t           pos_cmd;
	logic               code_found;
	logic               pos_found;
	logic [ENTRY_W-1:0] pos_value;

	assign pos_value = {row_q, col_q};

	always_comb begin
		code_cmd.cmp    = (state_q == ST_CMP);
		code_cmd.add    = apply && (func_q == FN_ADD_CODE) && !code_found;
		code_cmd.remove = apply && (func_q == FN_REM_CODE) && code_found;
		pos_cmd.cmp     = (state_q == ST_CMP);
		pos_cmd.add     = apply && (func_q == FN_ADD_POS) && !pos_found;
		pos_cmd.remove  = apply && (func_q == FN_REM_POS) && pos_found;
	end

	kef_list #(
		.SLOTS (CODE_SLOTS)
	) u_code_list (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (code_cmd),
		.value  (keycode_q),
		.found  (code_found)
	);

	kef_list #(
		.SLOTS (POSITION_SLOTS)
	) u_pos_list (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pos_cmd),
		.value  (pos_value),
		.found  (pos_found)
	);

	// Flag, held count and result of the word in the update step.
	logic              enabled_q;
	logic [HELD_W-1:0] held_q;
	logic              enabled_d;
	logic [HELD_W-1:0] held_d;
	logic              pass_d;
	logic              start_d;
	logic              stop_d;
	logic              match_d;

	always_comb begin
		enabled_d = enabled_q;
		held_d    = held_q;
		pass_d    = 1'b0;
		start_d   = 1'b0;
		stop_d    = 1'b0;
		match_d   = 1'b0;
		case (func_q)
			FN_KEY: begin
				// Control codes are tested in priority order and only on a press.
				if (pressed_q && keycode_q == toggle_code_q) begin
					enabled_d = !enabled_q;
				end else if (pressed_q && keycode_q == enable_code_q) begin
					enabled_d = 1'b1;
				end else if (pressed_q && keycode_q == disable_code_q) begin
					enabled_d = 1'b0;
					held_d    = '0;
				end else begin
					pass_d  = 1'b1;
					match_d = code_found || pos_found;
					if (enabled_q && match_d) begin
						if (pressed_q) begin
							start_d = (held_q == '0);
							if (held_q != HELD_MAX) begin
								held_d = held_q + 1'b1;
							end
						end else if (held_q != '0) begin
							held_d = held_q - 1'b1;
							stop_d = (held_q == {{(HELD_W-1){1'b0}}, 1'b1});
						end
					end
				end
			end
			FN_ADD_CODE, FN_REM_CODE: begin
				match_d = code_found;
			end
			FN_ADD_POS, FN_REM_POS: begin
				match_d = pos_found;
			end
			FN_ENABLE: begin
				enabled_d = 1'b1;
			end
			FN_DISABLE: begin
				enabled_d = 1'b0;
				held_d    = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			held_q    <= '0;
		end else if (apply) begin
			enabled_q <= enabled_d;
			held_q    <= held_d;
		end
	end

	// Output register: the result waits here while the input side is free again.
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (apply) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			m_tdata_q <= {{(OUT_DATA_W-5){1'b0}}, enabled_d, match_d, stop_d, start_d, pass_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

@@ src/kef_checker.sv @@
// Port-level checker for the key event match filter, bound to the top level.
`default_nettype none
`include "key_event_match_filter_macros.svh"

module kef_checker
	import kef_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata
);

	`KEF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	`KEF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "second word taken during a compare pass")

	`KEF_ASSERT_NOW(a_tone_exclusive, clk, arst_n, m_tvalid, !(m_tdata[1] && m_tdata[2]), "tone start and stop together")

	`KEF_ASSERT_NOW(a_tone_context, clk, arst_n, m_tvalid && (m_tdata[1] || m_tdata[2]), m_tdata[0] && m_tdata[3] && m_tdata[4], "tone without a passed, matched, active key")

endmodule

bind key_event_match_filter kef_checker u_kef_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
